// ===== sv/imu_tca_pkg.sv =====
// Shared types, constants and tables for the IMU tilt complementary average block.
package imu_tca_pkg;

   localparam int MaxEntries  = 32;
   localparam int CordicSteps = 16;
   localparam int StepW       = 5;
   localparam int IdxW        = $clog2(MaxEntries);
   localparam int CntW        = $clog2(MaxEntries + 1);
   localparam int SumW        = 16 + CntW;
   localparam int C100W       = CntW + 7;
   localparam int DenW        = 33 + C100W;
   localparam int DivNW       = 64;
   localparam int DivDW       = DenW;
   localparam int QDepth      = 2;
   localparam int QPtrW       = $clog2(QDepth);
   localparam int QCntW       = $clog2(QDepth + 1);
   localparam int CsrIdxW     = 2;

   localparam logic [CsrIdxW-1:0] CSR_WINDOW   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_CAL_LOW  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_CAL_HIGH = 2'd2;

   // gyro increment floor((rate*ms*65536 + 65500) / 131000) in two reciprocal steps
   localparam logic [32:0] GyroBias  = 33'd2147614000;  // 16394 * 131000
   localparam logic [16:0] GyroBiasQ = 17'd16394;
   localparam logic [17:0] GyroDiv   = 18'd131000;
   localparam logic [30:0] GyroRecip = 31'd1074331973;  // ceil(2^44 / 16375), exact below 2^30
   localparam logic [12:0] GyroRndLo = 13'd8187;        // 65500 >> 3
   localparam int          RecipSh   = 44;

   localparam logic signed [31:0] RollOff  = 32'sd38011;
   localparam logic signed [31:0] PitchOff = 32'sd103547;
   localparam logic signed [17:0] BlendG   = 18'sd62915;
   localparam logic signed [17:0] BlendA   = 18'sd2621;
   localparam logic signed [49:0] BlendRnd = 50'sd8388608;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic [15:0]        elapsed_ms;
   } req_type;

   typedef struct packed {
      logic signed [15:0] roll_deg;
      logic signed [15:0] pitch_deg;
      logic [15:0]        tilt_now;
      logic [15:0]        tilt_mean;
      logic signed [23:0] gravity_est;
      logic               cal_error;
      logic [5:0]         window_fill;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_GMUL, S_GU, S_GQ, S_GR, S_GF, S_GA, S_SQ, S_RT1, S_CR1, S_RT2, S_CR2,
      S_BLM, S_BLS, S_TSQ, S_RT3, S_EVR, S_EVW, S_APP, S_MEAN,
      S_DEN1, S_DEN2, S_GRAV, S_OUT
   } back_state_type;

   function automatic logic signed [31:0] atan_q16(input logic [StepW-1:0] i);
      logic signed [31:0] v;
      case (i)
         5'd0:    v = 32'sd2949120;
         5'd1:    v = 32'sd1740967;
         5'd2:    v = 32'sd919879;
         5'd3:    v = 32'sd466945;
         5'd4:    v = 32'sd234379;
         5'd5:    v = 32'sd117304;
         5'd6:    v = 32'sd58666;
         5'd7:    v = 32'sd29335;
         5'd8:    v = 32'sd14668;
         5'd9:    v = 32'sd7334;
         5'd10:   v = 32'sd3667;
         5'd11:   v = 32'sd1833;
         5'd12:   v = 32'sd917;
         5'd13:   v = 32'sd458;
         5'd14:   v = 32'sd229;
         5'd15:   v = 32'sd115;
         5'd16:   v = 32'sd57;
         5'd17:   v = 32'sd29;
         5'd18:   v = 32'sd14;
         5'd19:   v = 32'sd7;
         5'd20:   v = 32'sd4;
         5'd21:   v = 32'sd2;
         5'd22:   v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/imu_tilt_complementary_average.sv =====
// Top level of the IMU tilt estimator with complementary filter and moving average.
//
//   channel  direction  handshake             content
//   req_     in         req_valid/req_stall   one sample item (accel, gyro, elapsed ms)
//   rsp_     out        rsp_valid/rsp_stall   one result item per sample
//   csr_     in         csr_we                window_size, cal_low, cal_high
//
// One item at a time: three 32-step roots, two 16-step CORDIC passes, two 64-step
// divisions (mean, gravity) and 17 single-state steps, the last waiting for a free
// result register. Equal calibration points skip the gravity division.
// Synchronous active-high reset clears the filter state and the ring count.
// A two-item queue takes new samples while the back end works or a result is stalled.
module imu_tilt_complementary_average (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  imu_tca_pkg::req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output imu_tca_pkg::rsp_type            rsp_data,
   input  logic                            csr_we,
   input  logic [imu_tca_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0]                     csr_wdata
);
   import imu_tca_pkg::*;

   logic    q_valid, q_pop;
   req_type q_data;

   imu_tca_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_pop, .q_data
   );

   imu_tca_back u_back (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .q_valid, .q_pop, .q_data, .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

// ===== sv/imu_tca_ram.sv =====
// Generic single write port RAM with registered read.
module imu_tca_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/imu_tca_front.sv =====
// Front end: accepts sample items into a short queue ahead of the sequencer.
module imu_tca_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  imu_tca_pkg::req_type req_data,
   output logic                 q_valid,
   input  logic                 q_pop,
   output imu_tca_pkg::req_type q_data
);
   import imu_tca_pkg::*;

   req_type          mem_ff [QDepth];
   logic [QPtrW-1:0] wptr_ff, rptr_ff;
   logic [QCntW-1:0] cnt_ff;
   logic             push, pop;

   assign req_stall = (cnt_ff == QCntW'(QDepth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_data    = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            wptr_ff <= (wptr_ff == QPtrW'(QDepth - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= (rptr_ff == QPtrW'(QDepth - 1)) ? '0 : rptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end
endmodule

// ===== sv/imu_tca_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
module imu_tca_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [imu_tca_pkg::DivNW-1:0] dividend,
   input  logic [imu_tca_pkg::DivDW-1:0] divisor,
   output logic                          done,
   output logic [imu_tca_pkg::DivNW-1:0] quotient
);
   import imu_tca_pkg::*;

   logic [DivNW-1:0]         quo_ff;
   logic [DivDW-1:0]         rem_ff;
   logic [DivDW-1:0]         dvs_ff;
   logic [$clog2(DivNW)-1:0] cnt_ff;
   logic                     busy_ff, done_ff;
   logic [DivDW:0]           sh;
   logic                     fits;

   assign sh   = {rem_ff, quo_ff[DivNW-1]};
   assign fits = (sh >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         quo_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? DivDW'(sh - {1'b0, dvs_ff}) : DivDW'(sh);
         quo_ff <= {quo_ff[DivNW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == $clog2(DivNW)'(DivNW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== sv/imu_tca_root.sv =====
// Serial integer square root, two radicand bits per cycle.
module imu_tca_root (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] v_ff, r_ff, b_ff;
   logic        busy_ff, done_ff;
   logic [63:0] t;

   assign t = r_ff + b_ff;

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         v_ff <= radicand;
         r_ff <= '0;
         b_ff <= 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (v_ff >= t) begin
            v_ff <= v_ff - t;
            r_ff <= (r_ff >> 1) + b_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         b_ff <= b_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && b_ff == 64'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign root = r_ff[31:0];
endmodule

// ===== sv/imu_tca_cordic.sv =====
// Iterative CORDIC vectoring unit giving atan2 in Q16.16 degrees.
module imu_tca_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] x_in,
   input  logic signed [31:0] y_in,
   output logic               done,
   output logic signed [31:0] angle
);
   import imu_tca_pkg::*;

   logic signed [31:0] x_ff, y_ff, z_ff;
   logic [StepW-1:0]   i_ff;
   logic               busy_ff, done_ff;
   logic signed [31:0] dx, dy, tab;

   assign dx  = x_ff >>> i_ff;
   assign dy  = y_ff >>> i_ff;
   assign tab = atan_q16(i_ff);

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= '0;
      end else if (busy_ff) begin
         if (!y_ff[31]) begin
            x_ff <= x_ff + dy;
            y_ff <= y_ff - dx;
            z_ff <= z_ff + tab;
         end else begin
            x_ff <= x_ff - dy;
            y_ff <= y_ff + dx;
            z_ff <= z_ff - tab;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            i_ff <= '0;
            if (x_in == '0 && y_in == '0) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            if (i_ff == StepW'(CordicSteps - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               i_ff <= i_ff + 1'b1;
            end
         end
      end
   end

   assign done  = done_ff;
   assign angle = z_ff;
endmodule

// ===== sv/imu_tca_back.sv =====
// Back end: sequencer, filter state, tilt ring and result register.
module imu_tca_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [imu_tca_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0]                  csr_wdata,
   input  logic                         q_valid,
   output logic                         q_pop,
   input  imu_tca_pkg::req_type         q_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output imu_tca_pkg::rsp_type         rsp_data
);
   import imu_tca_pkg::*;

   back_state_type state_ff, state_in;
   logic           go_ff;
   req_type        item_ff;

   logic [4:0]         window_ff;
   logic signed [31:0] cal_low_ff, cal_high_ff;

   logic signed [32:0] px_ff, py_ff;
   logic [32:0]        ux_ff, uy_ff;
   logic [60:0]        mx_ff, my_ff;
   logic [16:0]        qx_ff, qy_ff, remx_ff, remy_ff;
   logic signed [31:0] gx_ff, gy_ff;
   logic [31:0]        m_ax_ff, m_ay_ff, m_az_ff;
   logic [31:0]        root_ff;
   logic signed [31:0] acc_r_ff, acc_p_ff;
   logic signed [49:0] bx1_ff, bx2_ff, by1_ff, by2_ff;
   logic signed [25:0] r_ff, p_ff;
   logic [51:0]        rr_ff, pp_ff;
   logic [15:0]        tilt_ff, mean_ff;
   logic               evict_ff;
   logic [IdxW-1:0]    head_ff;
   logic [CntW-1:0]    count_ff;
   logic [SumW-1:0]    tsum_ff;
   logic signed [SumW-1:0] asum_ff;
   logic [C100W-1:0]   cnt100_ff;
   logic signed [DenW-1:0] den_ff;
   logic signed [23:0] grav_ff;
   logic               err_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               div_start, div_done;
   logic [DivNW-1:0]   div_n, div_q;
   logic [DivDW-1:0]   div_d;
   logic               root_start, root_done;
   logic [63:0]        root_v;
   logic [31:0]        root_r;
   logic               cor_start, cor_done;
   logic signed [31:0] cor_x, cor_y, cor_z;
   logic               ram_we;
   logic [IdxW-1:0]    ram_waddr;
   logic [31:0]        ram_wdata, ram_rdata;

   logic               wait_st, unit_done, load_ok, den_zero;
   logic signed [49:0] rsum, psum;
   logic [IdxW:0]      slot_sum;
   logic [IdxW-1:0]    slot;
   logic [SumW-1:0]    amag;
   logic [DenW-1:0]    dmag;
   logic               gsign;
   logic signed [65:0] qv, gv;
   logic signed [23:0] gsat24;
   logic signed [32:0] dcal;

   function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
      logic signed [15:0] o;
      if (v > 26'sd32767) begin
         o = 16'sh7FFF;
      end else if (v < -26'sd32768) begin
         o = 16'sh8000;
      end else begin
         o = v[15:0];
      end
      return o;
   endfunction

   // angle plus increment (q - bias) * 65536 + f, held at the int32 limits
   function automatic logic signed [31:0] gyro_step(input logic signed [31:0] base,
                                                    input logic [16:0] q,
                                                    input logic [15:0] f);
      logic signed [32:0] inc;
      logic signed [35:0] acc;
      logic signed [31:0] o;
      inc = $signed({17'(q - GyroBiasQ), f});
      acc = 36'(base) + 36'(inc);
      if (acc > 36'sd2147483647) begin
         o = 32'sh7FFF_FFFF;
      end else if (acc < -36'sd2147483648) begin
         o = 32'sh8000_0000;
      end else begin
         o = acc[31:0];
      end
      return o;
   endfunction

   imu_tca_div u_div (
      .clock, .reset, .start(div_start), .dividend(div_n), .divisor(div_d),
      .done(div_done), .quotient(div_q)
   );

   imu_tca_root u_root (
      .clock, .reset, .start(root_start), .radicand(root_v), .done(root_done),
      .root(root_r)
   );

   imu_tca_cordic u_cordic (
      .clock, .reset, .start(cor_start), .x_in(cor_x), .y_in(cor_y),
      .done(cor_done), .angle(cor_z)
   );

   imu_tca_ram #(.Width(32), .Depth(MaxEntries)) u_ring (
      .clock, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(head_ff), .rdata(ram_rdata)
   );

   assign rsum = bx1_ff + bx2_ff + BlendRnd;
   assign psum = by1_ff + by2_ff + BlendRnd;

   assign slot_sum = (IdxW+1)'(head_ff) + (IdxW+1)'(count_ff);
   assign slot     = (slot_sum >= (IdxW+1)'(MaxEntries)) ?
                     IdxW'(slot_sum - (IdxW+1)'(MaxEntries)) : IdxW'(slot_sum);

   assign dcal     = $signed({cal_high_ff[31], cal_high_ff})
                   - $signed({cal_low_ff[31], cal_low_ff});
   assign den_zero = (cal_high_ff == cal_low_ff);
   assign amag     = asum_ff[SumW-1] ? SumW'(-asum_ff) : SumW'(asum_ff);
   assign dmag     = den_ff[DenW-1] ? DenW'(-den_ff) : DenW'(den_ff);
   assign gsign    = asum_ff[SumW-1] ^ den_ff[DenW-1];
   assign qv       = gsign ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
   assign gv       = qv + 66'sd65536;
   assign gsat24   = (gv > 66'sd8388607) ? 24'sh7FFFFF :
                     (gv < -66'sd8388608) ? 24'sh800000 : gv[23:0];

   assign wait_st   = state_ff inside {S_RT1, S_CR1, S_RT2, S_CR2,
                                       S_RT3, S_MEAN, S_GRAV};
   assign unit_done = div_done || root_done || cor_done;
   assign load_ok   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (q_valid) state_in = S_GMUL;
         S_GMUL:  state_in = S_GU;
         S_GU:    state_in = S_GQ;
         S_GQ:    state_in = S_GR;
         S_GR:    state_in = S_GF;
         S_GF:    state_in = S_GA;
         S_GA:    state_in = S_SQ;
         S_SQ:    state_in = S_RT1;
         S_RT1:   if (root_done) state_in = S_CR1;
         S_CR1:   if (cor_done) state_in = S_RT2;
         S_RT2:   if (root_done) state_in = S_CR2;
         S_CR2:   if (cor_done) state_in = S_BLM;
         S_BLM:   state_in = S_BLS;
         S_BLS:   state_in = S_TSQ;
         S_TSQ:   state_in = S_RT3;
         S_RT3:   if (root_done) state_in = S_EVR;
         S_EVR:   state_in = S_EVW;
         S_EVW:   state_in = S_APP;
         S_APP:   state_in = S_MEAN;
         S_MEAN:  if (div_done) state_in = S_DEN1;
         S_DEN1:  state_in = S_DEN2;
         S_DEN2:  state_in = S_GRAV;
         S_GRAV:  if (den_zero || div_done) state_in = S_OUT;
         S_OUT:   if (load_ok) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = 1'b0;
      div_start  = 1'b0;
      div_n      = '0;
      div_d      = '0;
      root_start = 1'b0;
      root_v     = '0;
      cor_start  = 1'b0;
      cor_x      = '0;
      cor_y      = '0;
      ram_we     = 1'b0;
      ram_waddr  = slot;
      ram_wdata  = {tilt_ff, item_ff.accel_x};
      unique case (state_ff)
         S_IDLE: q_pop = q_valid;
         S_RT1: begin
            root_start = !go_ff;
            root_v     = 64'(m_ax_ff + m_az_ff) << 16;
         end
         S_RT2: begin
            root_start = !go_ff;
            root_v     = 64'(m_ay_ff + m_az_ff) << 16;
         end
         S_RT3: begin
            root_start = !go_ff;
            root_v     = 64'(rr_ff + pp_ff);
         end
         S_CR1: begin
            cor_start = !go_ff;
            cor_x     = $signed(root_ff);
            cor_y     = $signed({{8{item_ff.accel_y[15]}}, item_ff.accel_y, 8'b0});
         end
         S_CR2: begin
            cor_start = !go_ff;
            cor_x     = $signed(root_ff);
            cor_y     = -$signed({{8{item_ff.accel_x[15]}}, item_ff.accel_x, 8'b0});
         end
         S_APP: ram_we = 1'b1;
         S_MEAN: begin
            div_start = !go_ff;
            div_n     = DivNW'(tsum_ff);
            div_d     = DivDW'(count_ff);
         end
         S_GRAV: begin
            div_start = !go_ff && !den_zero;
            div_n     = DivNW'(amag) << 32;
            div_d     = DivDW'(dmag);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= wait_st && !unit_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= 5'd20;
         cal_low_ff  <= 32'sd0;
         cal_high_ff <= 32'sd19661;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW:   window_ff   <= csr_wdata[4:0];
            CSR_CAL_LOW:  cal_low_ff  <= csr_wdata;
            CSR_CAL_HIGH: cal_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // filter and ring state
   always_ff @(posedge clock) begin
      if (reset) begin
         gx_ff    <= '0;
         gy_ff    <= '0;
         head_ff  <= '0;
         count_ff <= '0;
         tsum_ff  <= '0;
         asum_ff  <= '0;
      end else begin
         case (state_ff)
            S_GA: begin
               gx_ff <= gyro_step(gx_ff, qx_ff, mx_ff[RecipSh+15:RecipSh]);
               gy_ff <= gyro_step(gy_ff, qy_ff, my_ff[RecipSh+15:RecipSh]);
            end
            S_EVW: begin
               if (evict_ff) begin
                  tsum_ff  <= tsum_ff - SumW'(ram_rdata[31:16]);
                  asum_ff  <= asum_ff - SumW'($signed(ram_rdata[15:0]));
                  head_ff  <= (head_ff == IdxW'(MaxEntries - 1)) ? '0 : head_ff + 1'b1;
                  count_ff <= count_ff - 1'b1;
               end
            end
            S_APP: begin
               tsum_ff  <= tsum_ff + SumW'(tilt_ff);
               asum_ff  <= asum_ff + SumW'(item_ff.accel_x);
               count_ff <= count_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: if (q_valid) item_ff <= q_data;
         S_GMUL: begin
            px_ff <= $signed(item_ff.rate_x) * $signed({1'b0, item_ff.elapsed_ms});
            py_ff <= $signed(item_ff.rate_y) * $signed({1'b0, item_ff.elapsed_ms});
         end
         // rate product biased positive, then split by 131000 = 8 * 16375
         S_GU: begin
            ux_ff <= $unsigned(px_ff) + GyroBias;
            uy_ff <= $unsigned(py_ff) + GyroBias;
         end
         S_GQ: begin
            mx_ff <= ux_ff[32:3] * GyroRecip;
            my_ff <= uy_ff[32:3] * GyroRecip;
         end
         S_GR: begin
            qx_ff   <= mx_ff[RecipSh+16:RecipSh];
            qy_ff   <= my_ff[RecipSh+16:RecipSh];
            remx_ff <= 17'(ux_ff - 33'(mx_ff[RecipSh+16:RecipSh]) * 33'(GyroDiv));
            remy_ff <= 17'(uy_ff - 33'(my_ff[RecipSh+16:RecipSh]) * 33'(GyroDiv));
         end
         // fraction: floor((rem*65536 + 65500) / 131000)
         S_GF: begin
            mx_ff <= {remx_ff, GyroRndLo} * GyroRecip;
            my_ff <= {remy_ff, GyroRndLo} * GyroRecip;
         end
         S_SQ: begin
            m_ax_ff <= 32'($signed(item_ff.accel_x) * $signed(item_ff.accel_x));
            m_ay_ff <= 32'($signed(item_ff.accel_y) * $signed(item_ff.accel_y));
            m_az_ff <= 32'($signed(item_ff.accel_z) * $signed(item_ff.accel_z));
         end
         S_RT1, S_RT2: if (root_done) root_ff <= root_r;
         S_CR1: if (cor_done) acc_r_ff <= cor_z - RollOff;
         S_CR2: if (cor_done) acc_p_ff <= cor_z + PitchOff;
         S_BLM: begin
            bx1_ff <= gx_ff * BlendG;
            bx2_ff <= acc_r_ff * BlendA;
            by1_ff <= gy_ff * BlendG;
            by2_ff <= acc_p_ff * BlendA;
         end
         S_BLS: begin
            r_ff <= rsum[49:24];
            p_ff <= psum[49:24];
         end
         S_TSQ: begin
            rr_ff <= 52'(r_ff * r_ff);
            pp_ff <= 52'(p_ff * p_ff);
         end
         S_RT3: if (root_done) tilt_ff <= (root_r > 32'd65535) ? 16'hFFFF : root_r[15:0];
         S_EVR: evict_ff <= (32'(count_ff) > 32'(window_ff))
                         || (32'(count_ff) >= 32'(MaxEntries));
         S_MEAN: if (div_done) mean_ff <= div_q[15:0];
         S_DEN1: cnt100_ff <= C100W'(count_ff) * C100W'(100);
         S_DEN2: den_ff <= dcal * $signed({1'b0, cnt100_ff});
         S_GRAV: begin
            if (den_zero) begin
               err_ff  <= 1'b1;
               grav_ff <= asum_ff[SumW-1] ? 24'sh800000 : 24'sh7FFFFF;
            end else if (div_done) begin
               err_ff  <= 1'b0;
               grav_ff <= gsat24;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && load_ok) begin
         rsp_data_ff.roll_deg    <= sat16(r_ff);
         rsp_data_ff.pitch_deg   <= sat16(p_ff);
         rsp_data_ff.tilt_now    <= tilt_ff;
         rsp_data_ff.tilt_mean   <= mean_ff;
         rsp_data_ff.gravity_est <= grav_ff;
         rsp_data_ff.cal_error   <= err_ff;
         rsp_data_ff.window_fill <= 6'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && load_ok) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== sv/imu_tca_checker.sv =====
// Port-level checker for the tilt estimator, bound to the top level.
module imu_tca_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input imu_tca_pkg::rsp_type rsp_data
);
   import imu_tca_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.window_fill != 6'd0
                 && rsp_data.window_fill <= 6'(MaxEntries))
      else $error("window fill out of range");

   a_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cal_error |->
         rsp_data.gravity_est == 24'sh7FFFFF || rsp_data.gravity_est == 24'sh800000)
      else $error("calibration error without saturated gravity");
endmodule

bind imu_tilt_complementary_average imu_tca_checker u_chk (.*);
